>>> hdl/vpr_pkg.sv
// Shared constants, types and helper functions for the vector plane rotate block.
`timescale 1ns / 1ps
package vpr_pkg;

	// Width of the CORDIC datapath (angle frame is 2^32 per turn)
	localparam int CORDIC_W = 34;
	// Width of a rounded sine or cosine, range [-32768, 32768]
	localparam int SC_W = 17;
	localparam int SC_FRAC = 15;
	localparam int POS_FRAC = 16;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

	localparam logic [3:0] CMD_ROT_X = 4'd0;
	localparam logic [3:0] CMD_ROT_Y = 4'd1;
	localparam logic [3:0] CMD_ROT_Z = 4'd2;
	localparam logic [3:0] CMD_XY    = 4'd3;
	localparam logic [3:0] CMD_YZ    = 4'd4;
	localparam logic [3:0] CMD_XZ    = 4'd5;
	localparam logic [3:0] CMD_XW    = 4'd6;
	localparam logic [3:0] CMD_YW    = 4'd7;
	localparam logic [3:0] CMD_ZW    = 4'd8;
	localparam logic [3:0] CMD_PROJ  = 4'd9;

	localparam logic [1:0] IDX_X = 2'd0;
	localparam logic [1:0] IDX_Y = 2'd1;
	localparam logic [1:0] IDX_Z = 2'd2;
	localparam logic [1:0] IDX_W = 2'd3;

	localparam logic [0:0] REG_PROJ_DIST = 1'b0;

	localparam logic [31:0] ATAN_TURN32 [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic       valid;
		logic [3:0] cmd;
		logic       status;
	} vpr_ctl_t;

	// Round a Q30 CORDIC output to Q15 and clamp to one full unit
	function automatic logic signed [SC_W-1:0] sc_round(input logic signed [CORDIC_W-1:0] v);
		logic signed [CORDIC_W-1:0] half;
		logic signed [CORDIC_W-1:0] lim;
		logic signed [CORDIC_W-1:0] r;
		half = CORDIC_W'(1 << (SC_FRAC - 1));
		lim  = CORDIC_W'(1 << SC_FRAC);
		r    = (v + half) >>> (30 - SC_FRAC);
		if (r > lim) begin
			return SC_W'(lim);
		end else if (r < -lim) begin
			return SC_W'(-lim);
		end
		return SC_W'(r);
	endfunction

	// Commands whose first output takes +s (second takes -s)
	function automatic logic cmd_plus(input logic [3:0] cmd);
		unique case (cmd) inside
			CMD_ROT_Y, CMD_XY, CMD_YZ, CMD_XW: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

endpackage

>>> hdl/vpr_if.sv
// Request and result channel interfaces of the vector plane rotate block.
`timescale 1ns / 1ps
interface vpr_in_if #(parameter int CW = 32, parameter int AW = 16);
	logic                 valid;
	logic                 ready;
	logic [3:0]           command;
	logic [AW-1:0]        angle;
	logic signed [CW-1:0] x_in;
	logic signed [CW-1:0] y_in;
	logic signed [CW-1:0] z_in;
	logic signed [CW-1:0] w_in;

	modport source(output valid, command, angle, x_in, y_in, z_in, w_in, input ready);
	modport sink(input valid, command, angle, x_in, y_in, z_in, w_in, output ready);
endinterface

interface vpr_out_if #(parameter int CW = 32);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] x_out;
	logic signed [CW-1:0] y_out;
	logic signed [CW-1:0] z_out;
	logic signed [CW-1:0] w_out;
	logic                 status;

	modport source(output valid, x_out, y_out, z_out, w_out, status, input ready);
	modport sink(input valid, x_out, y_out, z_out, w_out, status, output ready);
endinterface

>>> hdl/vpr_cordic_cell.sv
// One CORDIC rotation cell with a fixed shift, carrying its request along.
`timescale 1ns / 1ps
module vpr_cordic_cell #(
	parameter int STEP = 0,
	parameter int PW = 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  vld_i,
	input  logic signed [vpr_pkg::CORDIC_W-1:0]   x_i,
	input  logic signed [vpr_pkg::CORDIC_W-1:0]   y_i,
	input  logic signed [vpr_pkg::CORDIC_W-1:0]   z_i,
	input  logic [PW-1:0]                         pass_i,
	output logic                                  vld_o,
	output logic signed [vpr_pkg::CORDIC_W-1:0]   x_o,
	output logic signed [vpr_pkg::CORDIC_W-1:0]   y_o,
	output logic signed [vpr_pkg::CORDIC_W-1:0]   z_o,
	output logic [PW-1:0]                         pass_o
);
	import vpr_pkg::*;

	logic signed [CORDIC_W-1:0] xs;
	logic signed [CORDIC_W-1:0] ys;
	logic signed [CORDIC_W-1:0] at;
	logic                       vld_q;
	logic signed [CORDIC_W-1:0] x_q;
	logic signed [CORDIC_W-1:0] y_q;
	logic signed [CORDIC_W-1:0] z_q;
	logic [PW-1:0]              pass_q;

	assign xs = x_i >>> STEP;
	assign ys = y_i >>> STEP;
	assign at = CORDIC_W'(ATAN_TURN32[STEP]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// rotate toward zero residual angle
			if (!z_i[CORDIC_W-1]) begin
				x_q <= x_i - ys;
				y_q <= y_i + xs;
				z_q <= z_i - at;
			end else begin
				x_q <= x_i + ys;
				y_q <= y_i - xs;
				z_q <= z_i + at;
			end
			pass_q <= pass_i;
		end
	end

	assign vld_o  = vld_q;
	assign x_o    = x_q;
	assign y_o    = y_q;
	assign z_o    = z_q;
	assign pass_o = pass_q;
endmodule

>>> hdl/vpr_div_cell.sv
// One restoring-division cell: a quotient bit for each of three lanes sharing a divisor.
`timescale 1ns / 1ps
module vpr_div_cell #(
	parameter int CW = 32,
	parameter int NW = 48,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [CW:0]   ud_i,
	input  logic [CW:0]   rem_i [3],
	input  logic [NW-1:0] nq_i [3],
	input  logic [PW-1:0] pass_i,
	output logic          vld_o,
	output logic [CW:0]   ud_o,
	output logic [CW:0]   rem_o [3],
	output logic [NW-1:0] nq_o [3],
	output logic [PW-1:0] pass_o
);
	logic [CW+1:0] t [3];
	logic          ge [3];
	logic [CW:0]   rem_n [3];
	logic          vld_q;
	logic [CW:0]   ud_q;
	logic [CW:0]   rem_q [3];
	logic [NW-1:0] nq_q [3];
	logic [PW-1:0] pass_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			t[k]     = {rem_i[k], nq_i[k][NW-1]};
			ge[k]    = t[k] >= {1'b0, ud_i};
			rem_n[k] = ge[k] ? (CW+1)'(t[k] - {1'b0, ud_i}) : t[k][CW:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ud_q   <= ud_i;
			pass_q <= pass_i;
			for (int k = 0; k < 3; k++) begin
				rem_q[k] <= rem_n[k];
				// shift out a numerator bit, shift in a quotient bit
				nq_q[k]  <= {nq_i[k][NW-2:0], ge[k]};
			end
		end
	end

	assign vld_o  = vld_q;
	assign ud_o   = ud_q;
	assign rem_o  = rem_q;
	assign nq_o   = nq_q;
	assign pass_o = pass_q;
endmodule

>>> hdl/vpr_rotate.sv
// Sine/cosine finish, plane operand multiply and rounded saturating sum.
`timescale 1ns / 1ps
module vpr_rotate #(
	parameter int CW = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vld_i,
	input  logic [3:0]                          cmd_i,
	input  logic [1:0]                          quad_i,
	input  logic signed [vpr_pkg::CORDIC_W-1:0] cx_i,
	input  logic signed [vpr_pkg::CORDIC_W-1:0] cy_i,
	input  logic signed [CW-1:0]                vec_i [4],
	output vpr_pkg::vpr_ctl_t                   ctl_o,
	output logic signed [CW-1:0]                vec_o [4]
);
	import vpr_pkg::*;

	localparam int PRW = CW + SC_W;
	localparam int TW = PRW + 2;
	localparam logic signed [TW-1:0] HALF = TW'(1 << (SC_FRAC - 1));

	logic signed [SC_W-1:0] rc, rs, c, s;
	logic                   vld_s1;
	logic [3:0]             cmd_s1;
	logic signed [SC_W-1:0] c_s1, s_s1;
	logic signed [CW-1:0]   vec_s1 [4];
	logic signed [CW-1:0]   a, b;
	logic                   vld_s2;
	logic [3:0]             cmd_s2;
	logic signed [PRW-1:0]  pac_s2, pbs_s2, pas_s2, pbc_s2;
	logic signed [CW-1:0]   vec_s2 [4];
	logic signed [TW-1:0]   r1, r2;
	logic                   ovf1, ovf2;
	logic signed [CW-1:0]   sat1, sat2;
	logic signed [CW-1:0]   vec_n [4];
	logic                   st_n;
	logic                   vld_s3;
	logic [3:0]             cmd_s3;
	logic                   st_s3;
	logic signed [CW-1:0]   vec_s3 [4];

	// map the first-quadrant result to the full turn
	always_comb begin
		rc = sc_round(cx_i);
		rs = sc_round(cy_i);
		case (quad_i)
			2'd0: begin c = rc;  s = rs;  end
			2'd1: begin c = -rs; s = rc;  end
			2'd2: begin c = -rc; s = -rs; end
			default: begin c = rs; s = -rc; end
		endcase
	end

	always_comb begin
		a = vec_s1[IDX_X];
		b = vec_s1[IDX_Y];
		case (cmd_s1) inside
			CMD_ROT_X, CMD_YZ: begin a = vec_s1[IDX_Y]; b = vec_s1[IDX_Z]; end
			CMD_ROT_Y, CMD_XZ: begin a = vec_s1[IDX_X]; b = vec_s1[IDX_Z]; end
			CMD_XW: begin a = vec_s1[IDX_X]; b = vec_s1[IDX_W]; end
			CMD_YW: begin a = vec_s1[IDX_Y]; b = vec_s1[IDX_W]; end
			CMD_ZW: begin a = vec_s1[IDX_Z]; b = vec_s1[IDX_W]; end
			default: begin a = vec_s1[IDX_X]; b = vec_s1[IDX_Y]; end
		endcase
	end

	always_comb begin
		r1   = (TW'(pac_s2) - TW'(pbs_s2) + HALF) >>> SC_FRAC;
		r2   = (TW'(pas_s2) + TW'(pbc_s2) + HALF) >>> SC_FRAC;
		ovf1 = !((&r1[TW-1:CW-1]) || !(|r1[TW-1:CW-1]));
		ovf2 = !((&r2[TW-1:CW-1]) || !(|r2[TW-1:CW-1]));
		sat1 = ovf1 ? {r1[TW-1], {(CW-1){~r1[TW-1]}}} : r1[CW-1:0];
		sat2 = ovf2 ? {r2[TW-1], {(CW-1){~r2[TW-1]}}} : r2[CW-1:0];
		vec_n = vec_s2;
		st_n  = ovf1 | ovf2;
		case (cmd_s2) inside
			CMD_ROT_X, CMD_YZ: begin vec_n[IDX_Y] = sat1; vec_n[IDX_Z] = sat2; end
			CMD_ROT_Y, CMD_XZ: begin vec_n[IDX_X] = sat1; vec_n[IDX_Z] = sat2; end
			CMD_ROT_Z, CMD_XY: begin vec_n[IDX_X] = sat1; vec_n[IDX_Y] = sat2; end
			CMD_XW: begin vec_n[IDX_X] = sat1; vec_n[IDX_W] = sat2; end
			CMD_YW: begin vec_n[IDX_Y] = sat1; vec_n[IDX_W] = sat2; end
			CMD_ZW: begin vec_n[IDX_Z] = sat1; vec_n[IDX_W] = sat2; end
			default: st_n = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd_i;
			c_s1   <= c;
			s_s1   <= cmd_plus(cmd_i) ? -s : s;
			vec_s1 <= vec_i;
			cmd_s2 <= cmd_s1;
			pac_s2 <= a * c_s1;
			pbs_s2 <= b * s_s1;
			pas_s2 <= a * s_s1;
			pbc_s2 <= b * c_s1;
			vec_s2 <= vec_s1;
			cmd_s3 <= cmd_s2;
			st_s3  <= st_n;
			vec_s3 <= vec_n;
		end
	end

	assign ctl_o.valid  = vld_s3;
	assign ctl_o.cmd    = cmd_s3;
	assign ctl_o.status = st_s3;
	assign vec_o        = vec_s3;
endmodule

>>> hdl/vector_plane_rotate_project.sv
// Top level of the vector plane rotate and projection pipeline.
`timescale 1ns / 1ps
// Takes one vector request per clock and returns one result per request, in order.
// Every request walks the chain of CORDIC cells followed by the chain of one-bit-per-cell
// divider cells used by the projection command. The whole pipeline advances whenever
// the result register is empty or being taken, so throughput is one request per cycle
// while the sink keeps up. proj_distance lives at byte address 0 of the APB port and
// must only be written while the pipeline is empty.
module vector_plane_rotate_project #(
	parameter int COORD_WIDTH = 32,
	parameter int ANGLE_WIDTH = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	vpr_in_if.sink                                      item,
	vpr_out_if.source                                   result,
	input  logic                                        psel,
	input  logic                                        penable,
	input  logic                                        pwrite,
	input  logic [0:0]                                  paddr,
	input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]   pwdata,
	output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]   prdata,
	output logic                                        pready
);
	import vpr_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int AW = ANGLE_WIDTH;
	localparam int DW = (CW > 32) ? 64 : 32;
	localparam int NW = CW + POS_FRAC;
	localparam int PW1 = 6 + 4 * CW;
	localparam int PW2 = 15 + 4 * CW;
	localparam logic [NW:0] HALF_RANGE = (NW+1)'(1) << (CW - 1);
	localparam logic signed [CW-1:0] VMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] VMIN = {1'b1, {(CW-1){1'b0}}};

	logic [CW-1:0] pd_q;
	logic          en;

	logic                       cv [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] cx [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] cy [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] cz [CORDIC_STEPS+1];
	logic [PW1-1:0]             cp [CORDIC_STEPS+1];

	logic signed [CW-1:0] rvec_i [4];
	vpr_ctl_t             rctl;
	logic signed [CW-1:0] rvec [4];

	logic signed [CW:0]   d;
	logic signed [CW-1:0] av [3];
	logic                 vld_s1;
	logic [CW:0]          ud_s1;
	logic [NW-1:0]        nq_s1 [3];
	logic [PW2-1:0]       pass_s1;
	logic [8:0]           flags;

	logic          dv [NW+1];
	logic [CW:0]   dud [NW+1];
	logic [CW:0]   drem [NW+1][3];
	logic [NW-1:0] dnq [NW+1][3];
	logic [PW2-1:0] dp [NW+1];

	logic           vld_s2;
	logic [NW:0]    q_s2 [3];
	logic [PW2-1:0] pass_s2;

	logic signed [CW-1:0] pv [3];
	logic                 povf [3];
	logic [NW:0]          negq [3];
	logic                 vld_s3;
	logic [3:0]           cmd_s3;
	logic                 st_s3;
	logic signed [CW-1:0] vec_s3 [4];

	// configuration port
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pd_q <= CW'(131072);
		end else if (psel && penable && pwrite && paddr == REG_PROJ_DIST) begin
			pd_q <= pwdata[CW-1:0];
		end
	end
	assign prdata = (paddr == REG_PROJ_DIST) ? DW'(pd_q) : '0;

	// hold the whole pipeline only while the result waits
	assign en         = !vld_s3 || result.ready;
	assign item.ready = en;

	// CORDIC chain
	assign cv[0] = item.valid;
	assign cx[0] = CORDIC_W'(CORDIC_GAIN_Q30);
	assign cy[0] = '0;
	assign cz[0] = CORDIC_W'({item.angle[AW-3:0], {(32-AW){1'b0}}});
	assign cp[0] = {item.command, item.angle[AW-1:AW-2],
		item.w_in, item.z_in, item.y_in, item.x_in};

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		vpr_cordic_cell #(.STEP(i), .PW(PW1)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (cv[i]),
			.x_i    (cx[i]),
			.y_i    (cy[i]),
			.z_i    (cz[i]),
			.pass_i (cp[i]),
			.vld_o  (cv[i+1]),
			.x_o    (cx[i+1]),
			.y_o    (cy[i+1]),
			.z_o    (cz[i+1]),
			.pass_o (cp[i+1])
		);
	end

	for (genvar k = 0; k < 4; k++) begin : g_unpack
		assign rvec_i[k] = cp[CORDIC_STEPS][k*CW +: CW];
	end

	vpr_rotate #(.CW(CW)) u_rotate (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (cv[CORDIC_STEPS]),
		.cmd_i  (cp[CORDIC_STEPS][PW1-1 -: 4]),
		.quad_i (cp[CORDIC_STEPS][4*CW +: 2]),
		.cx_i   (cx[CORDIC_STEPS]),
		.cy_i   (cy[CORDIC_STEPS]),
		.vec_i  (rvec_i),
		.ctl_o  (rctl),
		.vec_o  (rvec)
	);

	// projection setup: divisor, magnitudes and signs
	always_comb begin
		d = $signed({pd_q[CW-1], pd_q}) - $signed({rvec[IDX_W][CW-1], rvec[IDX_W]});
		for (int k = 0; k < 3; k++) begin
			av[k]          = rvec[k][CW-1] ? CW'(-rvec[k]) : rvec[k];
			flags[3*k]     = rvec[k][CW-1];
			flags[3*k + 1] = !rvec[k][CW-1] && (rvec[k] != '0);
			flags[3*k + 2] = rvec[k][CW-1] ^ d[CW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= rctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ud_s1   <= d[CW] ? (CW+1)'(-d) : d;
			pass_s1 <= {rctl.cmd, rctl.status, (d == '0), flags,
				rvec[IDX_W], rvec[IDX_Z], rvec[IDX_Y], rvec[IDX_X]};
			for (int k = 0; k < 3; k++) begin
				nq_s1[k] <= {av[k], {POS_FRAC{1'b0}}};
			end
		end
	end

	// divider chain
	assign dv[0]   = vld_s1;
	assign dud[0]  = ud_s1;
	assign dp[0]   = pass_s1;
	assign drem[0] = '{default: '0};
	assign dnq[0]  = nq_s1;

	for (genvar i = 0; i < NW; i++) begin : g_div
		vpr_div_cell #(.CW(CW), .NW(NW), .PW(PW2)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (dv[i]),
			.ud_i   (dud[i]),
			.rem_i  (drem[i]),
			.nq_i   (dnq[i]),
			.pass_i (dp[i]),
			.vld_o  (dv[i+1]),
			.ud_o   (dud[i+1]),
			.rem_o  (drem[i+1]),
			.nq_o   (dnq[i+1]),
			.pass_o (dp[i+1])
		);
	end

	// round the quotient to nearest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s2 <= dv[NW];
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pass_s2 <= dp[NW];
			for (int k = 0; k < 3; k++) begin
				q_s2[k] <= {1'b0, dnq[NW][k]}
					+ (NW+1)'({drem[NW][k], 1'b0} >= {1'b0, dud[NW]});
			end
		end
	end

	// apply sign and saturate the projected coordinates
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			negq[k] = (NW+1)'(0) - q_s2[k];
			povf[k] = 1'b0;
			if (pass_s2[4*CW + 9]) begin
				povf[k] = 1'b1;
				if (pass_s2[4*CW + 3*k + 1]) begin
					pv[k] = VMAX;
				end else if (pass_s2[4*CW + 3*k]) begin
					pv[k] = VMIN;
				end else begin
					pv[k] = '0;
				end
			end else if (pass_s2[4*CW + 3*k + 2]) begin
				if (q_s2[k] > HALF_RANGE) begin
					povf[k] = 1'b1;
					pv[k]   = VMIN;
				end else begin
					pv[k] = negq[k][CW-1:0];
				end
			end else begin
				if (q_s2[k] >= HALF_RANGE) begin
					povf[k] = 1'b1;
					pv[k]   = VMAX;
				end else begin
					pv[k] = q_s2[k][CW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3 <= pass_s2[PW2-1 -: 4];
			if (pass_s2[PW2-1 -: 4] == CMD_PROJ) begin
				vec_s3[IDX_X] <= pv[0];
				vec_s3[IDX_Y] <= pv[1];
				vec_s3[IDX_Z] <= pv[2];
				vec_s3[IDX_W] <= '0;
				st_s3         <= povf[0] | povf[1] | povf[2];
			end else begin
				for (int k = 0; k < 4; k++) begin
					vec_s3[k] <= pass_s2[k*CW +: CW];
				end
				st_s3 <= pass_s2[4*CW + 10];
			end
		end
	end

	assign result.valid  = vld_s3;
	assign result.x_out  = vec_s3[IDX_X];
	assign result.y_out  = vec_s3[IDX_Y];
	assign result.z_out  = vec_s3[IDX_Z];
	assign result.w_out  = vec_s3[IDX_W];
	assign result.status = st_s3;

`ifndef SYNTHESIS
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> cv[1])
		else $error("accepted request did not enter the first cell");
	a_proj_w_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && cmd_s3 == CMD_PROJ |-> result.w_out == '0)
		else $error("projection result with nonzero w");
	a_unused_ok: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && cmd_s3 > CMD_PROJ |-> !result.status)
		else $error("unused command raised status");
`endif
endmodule
